// ===== design/sscan_pkg.sv =====
// Package for the suspicious string scanner.
// Holds the counter sizing, the character codes and the per-byte class functions.
// No dependencies.
package sscan_pkg;

	localparam int unsigned MAX_BYTES = 4096;
	localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int unsigned RATIO_W   = 4;
	localparam int unsigned PROD_W    = CNT_W + RATIO_W;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(3);
	localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(MAX_BYTES);

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_AMP       = 8'h26;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER     = 8'h5F;
	localparam logic [7:0] CH_BACKTICK  = 8'h60;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_PIPE      = 8'h7C;
	localparam logic [7:0] CH_TILDE     = 8'h7E;

	function automatic logic is_special(input logic [7:0] c);
		logic alnum;
		alnum = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
		return !alnum && !(c inside {CH_MINUS, CH_UNDER, CH_DOT, CH_SPACE, CH_PLUS});
	endfunction

	function automatic logic is_bad_control(input logic [7:0] c);
		logic printable;
		printable = (c >= CH_SPACE) && (c <= CH_TILDE);
		return !printable && !(c inside {CH_TAB, CH_LF, CH_CR, CH_NUL});
	endfunction

endpackage

// ===== design/suspicious_string_scanner.sv =====
// Suspicious string scanner top level; depends on sscan_pkg.
// Registers each request, updates the per-string state and gives the verdict.
// A verdict is written into the output register when its last byte leaves stage one.
// Throughput: one byte per cycle; a last byte waits in stage one only while the
// previous verdict sits untaken in the output register.
// Reset clears all string state and sets the ratio register to three tenths.
module suspicious_string_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           suspicious,
	input  logic                           cfg_we,
	input  logic [sscan_pkg::RATIO_W-1:0]  cfg_data
);
	import sscan_pkg::*;

	logic [RATIO_W-1:0] ratio_q;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               adv_s1;

	logic [7:0]         prev_q;
	logic [7:0]         prev_prev_q;
	logic [CNT_W-1:0]   length_q;
	logic [CNT_W-1:0]   special_q;
	logic               flag_q;

	logic               hit;
	logic               flag_next;
	logic [CNT_W-1:0]   length_next;
	logic [CNT_W-1:0]   special_next;
	logic [PROD_W-1:0]  special_x10;
	logic [PROD_W-1:0]  ratio_x_len;
	logic               verdict;

	logic               out_valid_q;
	logic               out_q;

	// A byte in stage one may only move on if its verdict has a place to go.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		hit = is_bad_control(byte_s1)
			|| (byte_s1 inside {CH_BACKTICK, CH_SEMI, CH_PIPE})
			|| (prev_q == CH_DOLLAR && byte_s1 == CH_LPAREN)
			|| (prev_q == CH_AMP && byte_s1 == CH_AMP)
			|| (prev_prev_q == CH_DOT && prev_q == CH_DOT && byte_s1 == CH_SLASH)
			|| (prev_q == CH_BACKSLASH && (byte_s1 inside {CH_LOWER_X, CH_LOWER_U}));
		flag_next    = flag_q || hit;
		length_next  = (length_q < CNT_MAX) ? length_q + CNT_W'(1) : length_q;
		special_next = (is_special(byte_s1) && special_q < CNT_MAX)
			? special_q + CNT_W'(1) : special_q;
		special_x10  = PROD_W'({special_next, 3'b000}) + PROD_W'({special_next, 1'b0});
		ratio_x_len  = PROD_W'(ratio_q) * PROD_W'(length_next);
		verdict      = flag_next || (special_x10 > ratio_x_len);
	end

	// String state is cleared after the last byte so no sequence spans two strings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev_prev_q <= '0;
			length_q    <= '0;
			special_q   <= '0;
			flag_q      <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				prev_q      <= '0;
				prev_prev_q <= '0;
				length_q    <= '0;
				special_q   <= '0;
				flag_q      <= 1'b0;
			end else begin
				prev_q      <= byte_s1;
				prev_prev_q <= prev_q;
				length_q    <= length_next;
				special_q   <= special_next;
				flag_q      <= flag_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign suspicious = out_q;

endmodule
